[hw/rtl/rtu_fr_pkg.sv]
// Package for the RTU frame receiver: request and event codes, register
// indexes, reset values and the byte-wide reflected CRC-16 update.
// No dependencies.
package rtu_fr_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TX   = 2'd2;

  // Event codes carried by event_res.
  localparam logic [2:0] EV_MASTER_RESP = 3'd0;
  localparam logic [2:0] EV_FOR_US      = 3'd1;
  localparam logic [2:0] EV_OTHER_SLAVE = 3'd2;
  localparam logic [2:0] EV_BAD_LEN     = 3'd3;
  localparam logic [2:0] EV_BAD_ADDR    = 3'd4;
  localparam logic [2:0] EV_BAD_CRC     = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths fixed by the interface.
  localparam int unsigned LEN_W = 9;
  localparam int unsigned TMR_W = 16;

  // Reset values and protocol limits.
  localparam logic [7:0]       OWN_ADDRESS_RST = 8'd0;
  localparam logic [TMR_W-1:0] GAP_TIMEOUT_RST = 16'd750;
  localparam logic [TMR_W-1:0] IDLE_TIMEOUT_RST = 16'd1750;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST = 9'd256;
  localparam logic [TMR_W-1:0] TMR_MAX = 16'hFFFF;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 9'd5;
  localparam logic [7:0]       MAX_SLAVE_ADDR = 8'd247;
  localparam int unsigned      DEFAULT_FRAME_CAPACITY = 256;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[hw/rtl/rtu_frame_receiver.sv]
// RTU frame receiver: byte counting, CRC-16 check, gap and idle timers,
// and a registered result stage. Depends on rtu_fr_pkg.
//
// Usage. The input channel (in_valid_i / in_ready_o) carries one beat per
// event: a one-microsecond tick, a received byte, or a transmit notice. The
// output channel (out_valid_o / out_ready_i) returns exactly one result beat
// for every input beat, in order. frame_done_o marks the beat whose event
// ended a frame; event_res_o, frame_len_o and frame_address_o then describe
// that frame and are zero otherwise. rx_busy_o and bus_busy_o show the gap
// and idle timers after that event.
// The result of an accepted beat is registered and shown from the following
// cycle on. Throughput is one beat per cycle while the output is not stalled;
// it is set by the combinational state update, whose longest path is the
// byte-wide CRC step followed by the frame classification.
// When the receiver stalls, the result waits in the output register and a
// new beat is still taken in the same cycle that the waiting one drains;
// with the output register full and not drained, in_ready_o is low.
// Reset clears the frame state and both timers, loads the register defaults
// (own address 0, gap 750 us, idle 1750 us, capacity 256) and empties the
// output register. The configuration port is always ready.
module rtu_frame_receiver #(
  parameter int unsigned FRAME_CAPACITY = rtu_fr_pkg::DEFAULT_FRAME_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [7:0]                      rx_byte_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            frame_done_o,
  output logic [2:0]                      event_res_o,
  output logic [rtu_fr_pkg::LEN_W-1:0]    frame_len_o,
  output logic [7:0]                      frame_address_o,
  output logic                            rx_busy_o,
  output logic                            bus_busy_o,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rtu_fr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rtu_fr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LenW = rtu_fr_pkg::LEN_W;
  localparam int unsigned TmrW = rtu_fr_pkg::TMR_W;
  // The counter must hold the capacity itself.
  localparam int unsigned CntW = $clog2(FRAME_CAPACITY + 1);
  localparam logic [LenW-1:0] CapMax = LenW'(FRAME_CAPACITY);

  // Configuration registers.
  logic [7:0]      own_address_q;
  logic [TmrW-1:0] gap_timeout_q;
  logic [TmrW-1:0] idle_timeout_q;
  logic [LenW-1:0] max_frame_q;

  // Frame and timer state.
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            overflow_q, overflow_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      address_q, address_d;
  logic            gap_active_q, gap_active_d;
  logic [TmrW-1:0] gap_elapsed_q, gap_elapsed_d;
  logic            idle_active_q, idle_active_d;
  logic [TmrW-1:0] idle_elapsed_q, idle_elapsed_d;

  // Result register.
  logic            out_valid_q;
  logic            done_q, done_d;
  logic [2:0]      event_q, event_d;
  logic [LenW-1:0] flen_q, flen_d;
  logic [7:0]      faddr_q, faddr_d;
  logic            rx_busy_q;
  logic            bus_busy_q;

  logic            in_accept;
  logic [LenW-1:0] cap;
  logic [LenW-1:0] count_ext;

  // The output register can take a new result when it is empty or draining.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q  <= rtu_fr_pkg::OWN_ADDRESS_RST;
      gap_timeout_q  <= rtu_fr_pkg::GAP_TIMEOUT_RST;
      idle_timeout_q <= rtu_fr_pkg::IDLE_TIMEOUT_RST;
      max_frame_q    <= rtu_fr_pkg::MAX_FRAME_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rtu_fr_pkg::CFG_OWN_ADDRESS:  own_address_q  <= cfg_data_i[7:0];
        rtu_fr_pkg::CFG_GAP_TIMEOUT:  gap_timeout_q  <= cfg_data_i[TmrW-1:0];
        rtu_fr_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i[TmrW-1:0];
        rtu_fr_pkg::CFG_MAX_FRAME:    max_frame_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // The programmed capacity is clamped to what the counter was built for.
  assign cap       = (max_frame_q > CapMax) ? CapMax : max_frame_q;
  assign count_ext = LenW'(byte_count_q);

  // Next state and result for one beat.
  always_comb begin
    byte_count_d   = byte_count_q;
    overflow_d     = overflow_q;
    crc_d          = crc_q;
    address_d      = address_q;
    gap_active_d   = gap_active_q;
    gap_elapsed_d  = gap_elapsed_q;
    idle_active_d  = idle_active_q;
    idle_elapsed_d = idle_elapsed_q;
    done_d         = 1'b0;
    event_d        = rtu_fr_pkg::EV_MASTER_RESP;
    flen_d         = '0;
    faddr_d        = '0;

    unique case (req_type_i)
      rtu_fr_pkg::REQ_TICK: begin
        // Elapsed counts saturate, so the largest timeout never expires.
        if (gap_active_q && gap_elapsed_q != rtu_fr_pkg::TMR_MAX) begin
          gap_elapsed_d = gap_elapsed_q + 1'b1;
        end
        if (idle_active_q && idle_elapsed_q != rtu_fr_pkg::TMR_MAX) begin
          idle_elapsed_d = idle_elapsed_q + 1'b1;
        end
      end
      rtu_fr_pkg::REQ_BYTE: begin
        gap_active_d   = 1'b1;
        gap_elapsed_d  = '0;
        idle_active_d  = 1'b1;
        idle_elapsed_d = '0;
        if (count_ext < cap) begin
          if (byte_count_q == '0) begin
            address_d = rx_byte_i;
          end
          crc_d        = rtu_fr_pkg::crc_update(crc_q, rx_byte_i);
          byte_count_d = byte_count_q + 1'b1;
        end else begin
          overflow_d = 1'b1;
        end
      end
      rtu_fr_pkg::REQ_TX: begin
        idle_active_d  = 1'b1;
        idle_elapsed_d = '0;
      end
      default: ;
    endcase

    // The idle timer is tested first, then the gap timer ends the frame.
    if (idle_active_d && idle_elapsed_d > idle_timeout_q) begin
      idle_active_d  = 1'b0;
      idle_elapsed_d = '0;
    end

    if (gap_active_d && gap_elapsed_d > gap_timeout_q) begin
      gap_active_d  = 1'b0;
      gap_elapsed_d = '0;
      done_d        = 1'b1;
      flen_d        = LenW'(byte_count_d);
      faddr_d       = address_d;
      priority if (overflow_d || LenW'(byte_count_d) < rtu_fr_pkg::MIN_FRAME_LEN) begin
        event_d = rtu_fr_pkg::EV_BAD_LEN;
      end else if (address_d == 8'd0 || address_d > rtu_fr_pkg::MAX_SLAVE_ADDR) begin
        event_d = rtu_fr_pkg::EV_BAD_ADDR;
      end else if (crc_d != 16'd0) begin
        // A frame with a matching trailing CRC leaves a zero residue.
        event_d = rtu_fr_pkg::EV_BAD_CRC;
      end else if (own_address_q == 8'd0) begin
        event_d = rtu_fr_pkg::EV_MASTER_RESP;
      end else if (own_address_q == address_d) begin
        event_d = rtu_fr_pkg::EV_FOR_US;
      end else begin
        event_d = rtu_fr_pkg::EV_OTHER_SLAVE;
      end
      // Clear the frame for the next one.
      byte_count_d = '0;
      overflow_d   = 1'b0;
      crc_d        = rtu_fr_pkg::CRC_PRESET;
      address_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      overflow_q     <= 1'b0;
      crc_q          <= rtu_fr_pkg::CRC_PRESET;
      address_q      <= '0;
      gap_active_q   <= 1'b0;
      gap_elapsed_q  <= '0;
      idle_active_q  <= 1'b0;
      idle_elapsed_q <= '0;
    end else if (in_accept) begin
      byte_count_q   <= byte_count_d;
      overflow_q     <= overflow_d;
      crc_q          <= crc_d;
      address_q      <= address_d;
      gap_active_q   <= gap_active_d;
      gap_elapsed_q  <= gap_elapsed_d;
      idle_active_q  <= idle_active_d;
      idle_elapsed_q <= idle_elapsed_d;
    end
  end

  // Output register: control bit under reset, payload loaded on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      done_q     <= done_d;
      event_q    <= event_d;
      flen_q     <= flen_d;
      faddr_q    <= faddr_d;
      rx_busy_q  <= gap_active_d;
      bus_busy_q <= idle_active_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = done_q;
  assign event_res_o     = event_q;
  assign frame_len_o     = flen_q;
  assign frame_address_o = faddr_q;
  assign rx_busy_o       = rx_busy_q;
  assign bus_busy_o      = bus_busy_q;

`ifndef SYNTH
  // The byte counter never runs past the built capacity.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(byte_count_q) <= CapMax)
    else $error("byte counter exceeds capacity");

  // A received byte always leaves both timers running from zero.
  a_byte_starts_timers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && req_type_i == rtu_fr_pkg::REQ_BYTE |=>
      gap_active_q && gap_elapsed_q == '0 && idle_active_q)
    else $error("byte did not restart the timers");

  // A frame that ends stops the gap timer.
  a_done_stops_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !rx_busy_o)
    else $error("gap timer still running after frame end");

  // Any frame not flagged as a length error has at least the minimum length.
  a_good_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && event_res_o != rtu_fr_pkg::EV_BAD_LEN |->
      frame_len_o >= rtu_fr_pkg::MIN_FRAME_LEN)
    else $error("short frame not flagged as length error");
`endif

endmodule
